// File: design/segint_pkg.sv
// shared widths, payload types and helpers for the segment intersection test unit
package segint_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;

    localparam int NUM_DIFFS  = 12;
    localparam int NUM_PRODS  = 8;
    localparam int NUM_CROSS  = 4;

    // difference slots
    localparam int D_BAX = 0;
    localparam int D_BAY = 1;
    localparam int D_CAX = 2;
    localparam int D_CAY = 3;
    localparam int D_DAX = 4;
    localparam int D_DAY = 5;
    localparam int D_DCX = 6;
    localparam int D_DCY = 7;
    localparam int D_ACX = 8;
    localparam int D_ACY = 9;
    localparam int D_BCX = 10;
    localparam int D_BCY = 11;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
        coord_t dx;
        coord_t dy;
    } seg_pair_t;

    // per-item flags carried alongside the arithmetic
    typedef struct packed {
        logic func;
        logic box_ok;
        logic same_any;
        logic c_in_ab;
        logic d_in_ab;
        logic a_in_cd;
        logic b_in_cd;
    } seg_flags_t;

    // sign and zero of each orientation product
    typedef struct packed {
        logic [NUM_CROSS-1:0] neg;
        logic [NUM_CROSS-1:0] zero;
    } cross_sign_t;

    function automatic diff_t sub_ext(coord_t a, coord_t b);
        diff_t ea;
        diff_t eb;
        ea = diff_t'(a);
        eb = diff_t'(b);
        return ea - eb;
    endfunction

    function automatic logic in_range(coord_t p, coord_t u, coord_t v);
        coord_t mn;
        coord_t mx;
        mn = (u < v) ? u : v;
        mx = (u > v) ? u : v;
        return (p >= mn) && (p <= mx);
    endfunction

endpackage

// File: design/segint_prep.sv
// first stage: coordinate differences, bounding box and shared point checks
module segint_prep (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  valid_in,
    input  segint_pkg::seg_pair_t pair_in,
    input  logic                  func_in,
    output logic                  valid_out,
    output segint_pkg::diff_t     diff_out [segint_pkg::NUM_DIFFS],
    output segint_pkg::seg_flags_t flags_out
);

    logic                   valid_reg;
    segint_pkg::diff_t      diff_reg  [segint_pkg::NUM_DIFFS];
    segint_pkg::diff_t      diff_next [segint_pkg::NUM_DIFFS];
    segint_pkg::seg_flags_t flags_reg;
    segint_pkg::seg_flags_t flags_next;

    segint_pkg::coord_t ab_min_x, ab_max_x, ab_min_y, ab_max_y;
    segint_pkg::coord_t cd_min_x, cd_max_x, cd_min_y, cd_max_y;

    always_comb begin
        ab_min_x = (pair_in.ax < pair_in.bx) ? pair_in.ax : pair_in.bx;
        ab_max_x = (pair_in.ax > pair_in.bx) ? pair_in.ax : pair_in.bx;
        ab_min_y = (pair_in.ay < pair_in.by) ? pair_in.ay : pair_in.by;
        ab_max_y = (pair_in.ay > pair_in.by) ? pair_in.ay : pair_in.by;
        cd_min_x = (pair_in.cx < pair_in.dx) ? pair_in.cx : pair_in.dx;
        cd_max_x = (pair_in.cx > pair_in.dx) ? pair_in.cx : pair_in.dx;
        cd_min_y = (pair_in.cy < pair_in.dy) ? pair_in.cy : pair_in.dy;
        cd_max_y = (pair_in.cy > pair_in.dy) ? pair_in.cy : pair_in.dy;

        diff_next[segint_pkg::D_BAX] = segint_pkg::sub_ext(pair_in.bx, pair_in.ax);
        diff_next[segint_pkg::D_BAY] = segint_pkg::sub_ext(pair_in.by, pair_in.ay);
        diff_next[segint_pkg::D_CAX] = segint_pkg::sub_ext(pair_in.cx, pair_in.ax);
        diff_next[segint_pkg::D_CAY] = segint_pkg::sub_ext(pair_in.cy, pair_in.ay);
        diff_next[segint_pkg::D_DAX] = segint_pkg::sub_ext(pair_in.dx, pair_in.ax);
        diff_next[segint_pkg::D_DAY] = segint_pkg::sub_ext(pair_in.dy, pair_in.ay);
        diff_next[segint_pkg::D_DCX] = segint_pkg::sub_ext(pair_in.dx, pair_in.cx);
        diff_next[segint_pkg::D_DCY] = segint_pkg::sub_ext(pair_in.dy, pair_in.cy);
        diff_next[segint_pkg::D_ACX] = segint_pkg::sub_ext(pair_in.ax, pair_in.cx);
        diff_next[segint_pkg::D_ACY] = segint_pkg::sub_ext(pair_in.ay, pair_in.cy);
        diff_next[segint_pkg::D_BCX] = segint_pkg::sub_ext(pair_in.bx, pair_in.cx);
        diff_next[segint_pkg::D_BCY] = segint_pkg::sub_ext(pair_in.by, pair_in.cy);

        flags_next.func   = func_in;
        // touching boxes still count as overlapping
        flags_next.box_ok = !((ab_max_x < cd_min_x) || (cd_max_x < ab_min_x) ||
                              (ab_max_y < cd_min_y) || (cd_max_y < ab_min_y));
        flags_next.same_any =
            ((pair_in.ax == pair_in.cx) && (pair_in.ay == pair_in.cy)) ||
            ((pair_in.ax == pair_in.dx) && (pair_in.ay == pair_in.dy)) ||
            ((pair_in.bx == pair_in.cx) && (pair_in.by == pair_in.cy)) ||
            ((pair_in.bx == pair_in.dx) && (pair_in.by == pair_in.dy));
        flags_next.c_in_ab = segint_pkg::in_range(pair_in.cx, pair_in.ax, pair_in.bx) &&
                             segint_pkg::in_range(pair_in.cy, pair_in.ay, pair_in.by);
        flags_next.d_in_ab = segint_pkg::in_range(pair_in.dx, pair_in.ax, pair_in.bx) &&
                             segint_pkg::in_range(pair_in.dy, pair_in.ay, pair_in.by);
        flags_next.a_in_cd = segint_pkg::in_range(pair_in.ax, pair_in.cx, pair_in.dx) &&
                             segint_pkg::in_range(pair_in.ay, pair_in.cy, pair_in.dy);
        flags_next.b_in_cd = segint_pkg::in_range(pair_in.bx, pair_in.cx, pair_in.dx) &&
                             segint_pkg::in_range(pair_in.by, pair_in.cy, pair_in.dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg  <= diff_next;
            flags_reg <= flags_next;
        end
    end

    assign valid_out = valid_reg;
    assign diff_out  = diff_reg;
    assign flags_out = flags_reg;

endmodule

// File: design/segint_mult.sv
// second stage: the eight products behind the four orientation tests
module segint_mult (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   valid_in,
    input  segint_pkg::diff_t      diff_in [segint_pkg::NUM_DIFFS],
    input  segint_pkg::seg_flags_t flags_in,
    output logic                   valid_out,
    output segint_pkg::prod_t      prod_out [segint_pkg::NUM_PRODS],
    output segint_pkg::seg_flags_t flags_out
);

    logic                   valid_reg;
    segint_pkg::prod_t      prod_reg  [segint_pkg::NUM_PRODS];
    segint_pkg::prod_t      prod_next [segint_pkg::NUM_PRODS];
    segint_pkg::seg_flags_t flags_reg;

    function automatic segint_pkg::prod_t mul(segint_pkg::diff_t a, segint_pkg::diff_t b);
        segint_pkg::prod_t ea;
        segint_pkg::prod_t eb;
        ea = segint_pkg::prod_t'(a);
        eb = segint_pkg::prod_t'(b);
        return ea * eb;
    endfunction

    always_comb begin
        // orient(a,b,c) and orient(a,b,d)
        prod_next[0] = mul(diff_in[segint_pkg::D_BAX], diff_in[segint_pkg::D_CAY]);
        prod_next[1] = mul(diff_in[segint_pkg::D_BAY], diff_in[segint_pkg::D_CAX]);
        prod_next[2] = mul(diff_in[segint_pkg::D_BAX], diff_in[segint_pkg::D_DAY]);
        prod_next[3] = mul(diff_in[segint_pkg::D_BAY], diff_in[segint_pkg::D_DAX]);
        // orient(c,d,a) and orient(c,d,b)
        prod_next[4] = mul(diff_in[segint_pkg::D_DCX], diff_in[segint_pkg::D_ACY]);
        prod_next[5] = mul(diff_in[segint_pkg::D_DCY], diff_in[segint_pkg::D_ACX]);
        prod_next[6] = mul(diff_in[segint_pkg::D_DCX], diff_in[segint_pkg::D_BCY]);
        prod_next[7] = mul(diff_in[segint_pkg::D_DCY], diff_in[segint_pkg::D_BCX]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            flags_reg <= flags_in;
        end
    end

    assign valid_out = valid_reg;
    assign prod_out  = prod_reg;
    assign flags_out = flags_reg;

endmodule

// File: design/segint_cross.sv
// third stage: cross product subtraction, reduced to sign and zero flags
module segint_cross (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    valid_in,
    input  segint_pkg::prod_t       prod_in [segint_pkg::NUM_PRODS],
    input  segint_pkg::seg_flags_t  flags_in,
    output logic                    valid_out,
    output segint_pkg::cross_sign_t sign_out,
    output segint_pkg::seg_flags_t  flags_out
);

    logic                    valid_reg;
    segint_pkg::cross_sign_t sign_reg;
    segint_pkg::cross_sign_t sign_next;
    segint_pkg::seg_flags_t  flags_reg;
    segint_pkg::cross_t      cross_val [segint_pkg::NUM_CROSS];

    always_comb begin
        for (int k = 0; k < segint_pkg::NUM_CROSS; k++) begin
            cross_val[k] = segint_pkg::cross_t'(prod_in[2*k]) -
                           segint_pkg::cross_t'(prod_in[2*k+1]);
            sign_next.neg[k]  = cross_val[k][segint_pkg::CROSS_BITS-1];
            sign_next.zero[k] = (cross_val[k] == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sign_reg  <= sign_next;
            flags_reg <= flags_in;
        end
    end

    assign valid_out = valid_reg;
    assign sign_out  = sign_reg;
    assign flags_out = flags_reg;

endmodule

// File: design/segint_decide.sv
// last stage: combines orientation signs and box flags into the result register
module segint_decide (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    valid_in,
    input  segint_pkg::cross_sign_t sign_in,
    input  segint_pkg::seg_flags_t  flags_in,
    output logic                    valid_out,
    output logic                    result_out
);

    logic                       valid_reg;
    logic                       result_reg;
    logic                       result_next;
    logic [segint_pkg::NUM_CROSS-1:0] pos;
    logic on_c, on_d, on_a, on_b;
    logic proper;
    logic incl;
    logic strict;

    always_comb begin
        pos = ~sign_in.neg & ~sign_in.zero;
        on_c = sign_in.zero[0] && flags_in.c_in_ab;
        on_d = sign_in.zero[1] && flags_in.d_in_ab;
        on_a = sign_in.zero[2] && flags_in.a_in_cd;
        on_b = sign_in.zero[3] && flags_in.b_in_cd;
        // both pairs strictly on opposite sides
        proper = ((pos[0] && sign_in.neg[1]) || (sign_in.neg[0] && pos[1])) &&
                 ((pos[2] && sign_in.neg[3]) || (sign_in.neg[2] && pos[3]));
        incl   = flags_in.box_ok && (proper || on_c || on_d || on_a || on_b);
        strict = !flags_in.same_any && !(on_c && on_d) && !(on_a && on_b) && incl;
        result_next = flags_in.func ? strict : incl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign valid_out  = valid_reg;
    assign result_out = result_reg;

endmodule

// File: design/segment_intersection_test_unit.sv
// top level of the segment intersection test unit
//
// Each request on the s_ channel carries two segments (start and end point of
// each, signed grid coordinates) and s_func: 0 for the inclusive test, 1 for
// the strict test that rejects shared end points and segments lying wholly
// on the other. Every request gives exactly one response on the m_ channel,
// m_intersects, in request order.
// There are four register stages (differences and box checks, products,
// cross product signs, decision): the accepting edge loads the first stage
// and m_valid rises when the request has reached the decision stage, so the
// response can then be taken while m_ready is high.
// Throughput is one request per cycle while the output is empty or m_ready
// is high; the four-stage pipeline then takes a new request every cycle.
// When the receiver holds m_ready low with a response waiting, the whole
// pipeline freezes and s_ready drops, so nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline and holds s_ready low;
// there is no other state.
module segment_intersection_test_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  segint_pkg::coord_t s_first_start_x,
    input  segint_pkg::coord_t s_first_start_y,
    input  segint_pkg::coord_t s_first_end_x,
    input  segint_pkg::coord_t s_first_end_y,
    input  segint_pkg::coord_t s_second_start_x,
    input  segint_pkg::coord_t s_second_start_y,
    input  segint_pkg::coord_t s_second_end_x,
    input  segint_pkg::coord_t s_second_end_y,
    input  logic               s_func,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_intersects
);

    logic                    en;
    segint_pkg::seg_pair_t   pair;
    logic                    v1, v2, v3;
    segint_pkg::diff_t       diff [segint_pkg::NUM_DIFFS];
    segint_pkg::prod_t       prod [segint_pkg::NUM_PRODS];
    segint_pkg::seg_flags_t  flags1, flags2, flags3;
    segint_pkg::cross_sign_t sign3;

    // pipeline advances whenever the output slot is free or being taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en && aresetn;

    assign pair.ax = s_first_start_x;
    assign pair.ay = s_first_start_y;
    assign pair.bx = s_first_end_x;
    assign pair.by = s_first_end_y;
    assign pair.cx = s_second_start_x;
    assign pair.cy = s_second_start_y;
    assign pair.dx = s_second_end_x;
    assign pair.dy = s_second_end_y;

    segint_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s_valid),
        .pair_in   (pair),
        .func_in   (s_func),
        .valid_out (v1),
        .diff_out  (diff),
        .flags_out (flags1)
    );

    segint_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (v1),
        .diff_in   (diff),
        .flags_in  (flags1),
        .valid_out (v2),
        .prod_out  (prod),
        .flags_out (flags2)
    );

    segint_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (v2),
        .prod_in   (prod),
        .flags_in  (flags2),
        .valid_out (v3),
        .sign_out  (sign3),
        .flags_out (flags3)
    );

    segint_decide u_decide (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .valid_in   (v3),
        .sign_in    (sign3),
        .flags_in   (flags3),
        .valid_out  (m_valid),
        .result_out (m_intersects)
    );

endmodule
